// ===== src/pdhfc_pkg.sv =====
`timescale 1ns / 1ps

package pdhfc_pkg;

	// Field widths
	localparam int unsigned HEAD_W  = 12;
	localparam int unsigned ERR_W   = 12;
	localparam int unsigned DERIV_W = 13;
	localparam int unsigned REG_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// Packed stream widths (whole bytes)
	localparam int unsigned S_TDATA_W = 24;
	localparam int unsigned M_TDATA_W = 48;

	// Heading wrap limits in tenths of a degree
	localparam logic signed [DERIV_W-1:0] WRAP_HALF = 13'sd1800;
	localparam logic signed [DERIV_W-1:0] WRAP_FULL = 13'sd3600;

	// PWM counter top
	localparam logic [REG_W-1:0] PWM_TOP = 16'hFFFF;

	// Register reset values
	localparam logic [REG_W-1:0] CENTER_RST = 16'd2765;
	localparam logic [REG_W-1:0] MIN_RST    = 16'd2028;
	localparam logic [REG_W-1:0] MAX_RST    = 16'd3502;
	localparam logic [REG_W-1:0] KP_RST     = 16'd384;   // 1.5 in Q8.8
	localparam logic [REG_W-1:0] KD_RST     = 16'd17920; // 70.0 in Q8.8

	// Configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_WIDTH = 3'd0,
		REG_MIN_WIDTH    = 3'd1,
		REG_MAX_WIDTH    = 3'd2,
		REG_PROP_GAIN    = 3'd3,
		REG_DERIV_GAIN   = 3'd4
	} cfg_reg_t;

endpackage

// ===== src/pd_heading_fan_controller_unit.sv =====
`timescale 1ns / 1ps

// PD heading controller for a fan drive.
// Input stream (s_axis_*): one transaction carries a measured and a desired
// heading in tenths of a degree. Output stream (m_axis_*): one transaction per
// input carries the clamped pulse width, its PWM compare value and the wrapped
// heading error. The configuration channel (cfg_*) writes the center width,
// clamp limits and the two Q8.8 gains; cfg_ready is always high and writes are
// expected only while no sample is in flight.
// Two register stages (input, result): a sample is captured in the input
// register, then moves to the result register and from there onto m_axis.
// Throughput: one sample per cycle while m_axis_tready is high. The error
// wrap, both gain multiplies, the sum, truncation and clamp all sit between
// the input and result registers, so nothing iterates.
// When the receiver stalls, the result register holds its transaction and the
// input stage behind it fills up; s_axis_tready falls only once both stages
// hold a sample, and the pipe moves again in the cycle m_axis_tready returns.
// Reset clears all valid flags and the stored previous error, and loads the
// configuration registers with their default values.
module pd_heading_fan_controller_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pdhfc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pdhfc_pkg::REG_W-1:0]            cfg_data,
	// Sample input stream
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// [11:0] measured_heading, [23:12] desired_heading
	input  logic [pdhfc_pkg::S_TDATA_W-1:0]        s_axis_tdata,
	// Result output stream
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [15:0] pulse_width, [31:16] compare_value, [43:32] wrapped_error, rest zero
	output logic [pdhfc_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

	import pdhfc_pkg::*;

	// Configuration registers
	logic [REG_W-1:0] center_q, min_q, max_q, kp_q, kd_q;

	// Pipeline state
	logic                      v_s1, out_v_q;
	logic [HEAD_W-1:0]         meas_s1, want_s1;
	logic signed [ERR_W-1:0]   last_error_q;
	logic [REG_W-1:0]          pw_q;
	logic signed [ERR_W-1:0]   err_q;

	// Handshake chain
	logic out_load, s1_free;

	// Error wrap and products
	logic signed [DERIV_W-1:0] diff, diff_wrap, deriv;
	logic signed [ERR_W-1:0]   err;
	logic signed [28:0]        pprod;
	logic signed [29:0]        dprod;

	// Sum and clamp
	logic signed [31:0]        acc;
	logic signed [23:0]        acc_floor;
	logic signed [24:0]        pw_trunc;
	logic signed [24:0]        max_ext, min_ext;
	logic [REG_W-1:0]          pw_sat;

	// Pipeline advance: the input stage moves when the result register frees up
	assign out_load      = v_s1 & (~out_v_q | m_axis_tready);
	assign s1_free       = ~v_s1 | out_load;
	assign s_axis_tready = s1_free;
	assign cfg_ready     = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RST;
			min_q    <= MIN_RST;
			max_q    <= MAX_RST;
			kp_q     <= KP_RST;
			kd_q     <= KD_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_WIDTH: center_q <= cfg_data;
				REG_MIN_WIDTH:    min_q    <= cfg_data;
				REG_MAX_WIDTH:    max_q    <= cfg_data;
				REG_PROP_GAIN:    kp_q     <= cfg_data;
				REG_DERIV_GAIN:   kd_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid flags and stored error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			out_v_q      <= 1'b0;
			last_error_q <= '0;
		end else begin
			if (s1_free) begin
				v_s1 <= s_axis_tvalid;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (out_load) begin
				last_error_q <= err;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s1_free) begin
			meas_s1 <= s_axis_tdata[HEAD_W-1:0];
			want_s1 <= s_axis_tdata[2*HEAD_W-1:HEAD_W];
		end
	end

	// Error wrap, derivative and gain products
	always_comb begin
		diff = $signed({1'b0, want_s1}) - $signed({1'b0, meas_s1});
		if (diff > WRAP_HALF) begin
			diff_wrap = diff - WRAP_FULL;
		end else if (diff < -WRAP_HALF) begin
			diff_wrap = diff + WRAP_FULL;
		end else begin
			diff_wrap = diff;
		end
		err   = diff_wrap[ERR_W-1:0];
		deriv = $signed({err[ERR_W-1], err}) - $signed({last_error_q[ERR_W-1], last_error_q});
		pprod = $signed({1'b0, kp_q}) * err;
		dprod = $signed({1'b0, kd_q}) * deriv;
	end

	// Sum, truncate toward zero, clamp
	always_comb begin
		acc = $signed({8'b0, center_q, 8'b0})
		    + $signed({{3{pprod[28]}}, pprod})
		    + $signed({{2{dprod[29]}}, dprod});
		acc_floor = acc[31:8];
		if (acc[31] && (acc[7:0] != 8'd0)) begin
			pw_trunc = $signed({acc_floor[23], acc_floor}) + 25'sd1;
		end else begin
			pw_trunc = $signed({acc_floor[23], acc_floor});
		end
		max_ext = $signed({9'b0, max_q});
		min_ext = $signed({9'b0, min_q});
		if (pw_trunc > max_ext) begin
			pw_sat = max_q;
		end else if (pw_trunc < min_ext) begin
			pw_sat = min_q;
		end else begin
			pw_sat = pw_trunc[REG_W-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			pw_q  <= pw_sat;
			err_q <= err;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'b0, err_q, PWM_TOP - pw_q, pw_q};

`ifndef SYNTHESIS
	// Input side only stalls when stage 1 holds a sample
	a_stall_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> v_s1)
		else $error("input stalled with empty first stage");

	// Wrapped error of the held sample stays within the half circle
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (err <= 12'sd1800) && (err >= -12'sd1800))
		else $error("wrapped error out of range");

	// Stored error follows the sample that just left stage 1
	a_last_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> last_error_q == $past(err))
		else $error("previous error not stored");

	// A stalled result is not overwritten
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(pw_q)
			&& $stable(err_q))
		else $error("stalled result changed");
`endif

endmodule
